/* src/gpsp_pkg.sv */
package gpsp_pkg;

	// Access kinds carried in the request's tuser field.
	typedef enum logic [2:0] {
		FUNC_DATA_WR = 3'd0,
		FUNC_CTRL_WR = 3'd1,
		FUNC_DATA_RD = 3'd2,
		FUNC_STAT_RD = 3'd3,
		FUNC_BUTTON  = 3'd4
	} func_t;

	localparam int FuncWidth   = 3;
	localparam int InDataWidth = 24;
	localparam int OutWidth    = 16;

	// One accepted request.
	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] write_data;
		logic [3:0]  button_index;
		logic        button_pressed;
	} item_t;

	// One result.
	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] status_bits;
		logic       irq_pulse;
	} result_t;

endpackage

/* src/gpsp_in_stage.sv */
module gpsp_in_stage
	import gpsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [InDataWidth-1:0] s_tdata,
	input  logic [FuncWidth-1:0]   s_tuser,
	input  logic                   advance,
	output logic                   valid_s1,
	output item_t                  item_s1
);

	logic v_s1;

	// The stage takes a new request when empty or when its request moves on.
	assign s_tready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func           <= s_tuser;
			item_s1.write_data     <= s_tdata[15:0];
			item_s1.button_index   <= s_tdata[19:16];
			item_s1.button_pressed <= s_tdata[20];
		end
	end

	assign valid_s1 = v_s1;

endmodule

/* src/gpsp_engine.sv */
module gpsp_engine
	import gpsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	output result_t result
);

	typedef enum logic [2:0] {
		PhIdle  = 3'b001,
		PhCmd   = 3'b010,
		PhReply = 3'b100
	} phase_t;

	localparam logic [2:0] LastPos = 3'd4;
	localparam logic [2:0] StReset = 3'b101;

	logic [2:0]  status_q, status_d;
	logic [15:0] control_q, control_d;
	logic [2:0]  pos_q, pos_d, pos_inc;
	phase_t      phase_q, phase_d;
	logic [15:0] buttons_q, buttons_d;
	logic [7:0]  id_q, id_d;
	logic [7:0]  btn_lo_q, btn_lo_d;
	logic [7:0]  btn_hi_q, btn_hi_d;
	logic [7:0]  wbyte;
	logic [7:0]  reply;
	logic [7:0]  rd;
	logic        irq;

	assign wbyte   = item.write_data[7:0];
	assign pos_inc = pos_q + 3'd1;

	always_comb begin
		unique case (pos_q)
			3'd0:    reply = 8'h00;
			3'd1:    reply = id_q;
			3'd2:    reply = 8'h5a;
			3'd3:    reply = btn_lo_q;
			3'd4:    reply = btn_hi_q;
			default: reply = 8'h00;
		endcase
	end

	always_comb begin
		status_d  = status_q;
		control_d = control_q;
		pos_d     = pos_q;
		phase_d   = phase_q;
		buttons_d = buttons_q;
		id_d      = id_q;
		btn_lo_d  = btn_lo_q;
		btn_hi_d  = btn_hi_q;
		rd        = 8'h00;
		irq       = 1'b0;
		case (item.func)
			FUNC_DATA_WR: begin
				if (phase_q == PhCmd) begin
					irq = 1'b1;
					if (wbyte[6]) begin
						pos_d   = 3'd1;
						phase_d = PhReply;
						if (wbyte == 8'h42) begin
							id_d = 8'h41;
						end else if (wbyte == 8'h43) begin
							id_d = 8'h43;
						end
					end else begin
						phase_d = PhIdle;
					end
				end else if (phase_q == PhReply) begin
					pos_d = pos_inc;
					if (pos_inc == LastPos) begin
						phase_d = PhIdle;
					end else begin
						irq = 1'b1;
					end
				end else if (wbyte == 8'h01) begin
					// Start of a transfer; the pad bits are sampled only with DTR set.
					status_d = {1'b0, 1'b1, status_q[0]};
					pos_d    = 3'd0;
					phase_d  = PhCmd;
					if (control_q[1]) begin
						irq = 1'b1;
						if (control_q[13]) begin
							btn_lo_d = 8'hff;
							btn_hi_d = 8'hff;
						end else begin
							btn_lo_d = buttons_q[7:0];
							btn_hi_d = buttons_q[15:8];
						end
					end
				end
			end
			FUNC_CTRL_WR: begin
				control_d = item.write_data & 16'hffef;
				if (control_d[6] || control_d == 16'h0000) begin
					status_d = StReset;
					pos_d    = 3'd0;
					phase_d  = PhIdle;
				end
			end
			FUNC_DATA_RD: begin
				if (status_q[1]) begin
					rd = reply;
					if (pos_q == LastPos) begin
						status_d = {1'b1, 1'b0, status_q[0]};
						if (phase_q == PhReply) begin
							phase_d = PhIdle;
						end
					end
				end
			end
			FUNC_BUTTON: begin
				buttons_d[item.button_index] = !item.button_pressed;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= StReset;
			control_q <= 16'h0000;
			pos_q     <= 3'd0;
			phase_q   <= PhIdle;
			buttons_q <= 16'hffff;
			id_q      <= 8'h41;
			btn_lo_q  <= 8'hff;
			btn_hi_q  <= 8'hff;
		end else if (advance) begin
			status_q  <= status_d;
			control_q <= control_d;
			pos_q     <= pos_d;
			phase_q   <= phase_d;
			buttons_q <= buttons_d;
			id_q      <= id_d;
			btn_lo_q  <= btn_lo_d;
			btn_hi_q  <= btn_hi_d;
		end
	end

	assign result.read_data   = rd;
	assign result.status_bits = status_d;
	assign result.irq_pulse   = irq;

	a_tx_ready: assert property (@(posedge clk) disable iff (!arst_n)
		status_q[0])
		else $error("transmit ready bit dropped");

	a_phase_used: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("transfer phase lost its one-hot code");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LastPos)
		else $error("reply position beyond the last byte");

	a_irq_src: assert property (@(posedge clk) disable iff (!arst_n)
		advance && irq |-> item.func == FUNC_DATA_WR)
		else $error("interrupt from an access other than a data write");

endmodule

/* src/game_pad_serial_port_core.sv */
// Channel   Dir  tdata (low bit up)                              tuser
// s_*       in   write_data[15:0], button_index[19:16],          func[2:0]
//                button_pressed[20], zero[23:21]
// m_*       out  read_data[7:0], status_bits[10:8],              -
//                irq_pulse[11], zero[15:12]
//
// From acceptance a request passes the input register, where the port state
// is read and updated, and then the output register. One request is accepted
// every cycle while the output is not stalled; the state update is a single
// level of logic, so a request sees the state left by the one just before it.
// arst_n clears all port state to its power-up values at once.
// A stalled output holds its result and the input stage keeps one request.
module game_pad_serial_port_core
	import gpsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [InDataWidth-1:0] s_tdata,  // write_data, button_index, button_pressed
	input  logic [FuncWidth-1:0]   s_tuser,  // func
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OutWidth-1:0]    m_tdata   // read_data, status_bits, irq_pulse
);

	logic    valid_s1;
	item_t   item_s1;
	result_t result;
	logic    advance;
	logic    m_valid_q;
	result_t m_res_q;

	assign advance = valid_s1 && (!m_valid_q || m_tready);

	gpsp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	gpsp_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_res_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'h0, m_res_q.irq_pulse, m_res_q.status_bits, m_res_q.read_data};

endmodule

/* tb/game_pad_serial_port_core_tb.sv */
module game_pad_serial_port_core_tb;
	import gpsp_pkg::*;

	localparam logic [2:0] ST_TX_READY = 3'b001;
	localparam logic [2:0] ST_RX_READY = 3'b010;
	localparam logic [2:0] ST_TX_EMPTY = 3'b100;

	localparam logic [15:0] CTL_DTR       = 16'h0002;
	localparam logic [15:0] CTL_RESET_ERR = 16'h0010;
	localparam logic [15:0] CTL_RESET     = 16'h0040;
	localparam logic [15:0] CTL_PORT2     = 16'h2000;

	localparam logic [7:0] CMD_START   = 8'h01;
	localparam logic [7:0] CMD_SELECT  = 8'h40;
	localparam logic [7:0] CMD_READ_42 = 8'h42;
	localparam logic [7:0] CMD_READ_43 = 8'h43;
	localparam logic [7:0] ID_PAD_41   = 8'h41;
	localparam logic [7:0] ID_PAD_43   = 8'h43;
	localparam logic [7:0] REPLY_HEAD  = 8'h00;
	localparam logic [7:0] REPLY_MARK  = 8'h5A;
	localparam logic [7:0] ALL_RELEASED = 8'hFF;
	localparam logic [2:0] LAST_POS    = 3'd4;

	// Access kinds the block must ignore.
	localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

	localparam int RANDOM_ACCESSES = 1100;
	localparam int STALL_LIMIT     = 4000;
	localparam int LONG_HOLD       = 120;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_AWAIT_CMD = 2'd1,
		PH_REPLY     = 2'd2,
		PH_SPARE     = 2'd3
	} pad_phase_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [InDataWidth-1:0] s_tdata = '0;
	logic [FuncWidth-1:0]   s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OutWidth-1:0]    m_tdata;

	game_pad_serial_port_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Predictor state of the port.
	logic [2:0]  pad_status = ST_TX_READY | ST_TX_EMPTY;
	logic [15:0] pad_ctl = '0;
	logic [2:0]  pad_pos = '0;
	pad_phase_t  pad_phase = PH_IDLE;
	logic [15:0] pad_buttons = 16'hFFFF;
	logic [7:0]  pad_id = ID_PAD_41;
	logic [7:0]  pad_lo = ALL_RELEASED;
	logic [7:0]  pad_hi = ALL_RELEASED;

	item_t   queued_accesses[$];
	result_t expected_port_results[$];
	item_t   offered;

	int errors = 0;
	int results_checked = 0;
	int func_seen[8];
	int transfers_started = 0;
	int replies_drained = 0;
	int send_gap = 0;
	int sender_calm = 0;
	int recv_gap = 0;
	int receiver_calm = 0;
	int long_holds = 0;
	int idle_cycles = 0;

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic result_t pad_port_access(item_t it);
		result_t     r;
		logic [7:0]  b;
		logic [15:0] ctl;
		r = '0;
		case (it.func)
			FUNC_DATA_WR: begin
				b = it.write_data[7:0];
				if (pad_phase == PH_AWAIT_CMD) begin
					if ((b & CMD_SELECT) != 0) begin
						pad_pos = 3'd1;
						pad_phase = PH_REPLY;
						if (b == CMD_READ_42)
							pad_id = ID_PAD_41;
						else if (b == CMD_READ_43)
							pad_id = ID_PAD_43;
					end else begin
						pad_phase = PH_IDLE;
					end
					r.irq_pulse = 1'b1;
				end else if (pad_phase == PH_REPLY) begin
					pad_pos = pad_pos + 3'd1;
					if (pad_pos == LAST_POS)
						pad_phase = PH_IDLE;
					else
						r.irq_pulse = 1'b1;
				end else if (b == CMD_START) begin
					// The unused phase falls through here like idle.
					pad_status = (pad_status & ~ST_TX_EMPTY) | ST_RX_READY;
					pad_pos = '0;
					pad_phase = PH_AWAIT_CMD;
					transfers_started++;
					if ((pad_ctl & CTL_DTR) != 0) begin
						if ((pad_ctl & CTL_PORT2) != 0) begin
							pad_lo = ALL_RELEASED;
							pad_hi = ALL_RELEASED;
						end else begin
							pad_lo = pad_buttons[7:0];
							pad_hi = pad_buttons[15:8];
						end
						r.irq_pulse = 1'b1;
					end
				end
			end
			FUNC_CTRL_WR: begin
				ctl = it.write_data & ~CTL_RESET_ERR;
				pad_ctl = ctl;
				if ((ctl & CTL_RESET) != 0 || ctl == 0) begin
					pad_status = ST_TX_READY | ST_TX_EMPTY;
					pad_pos = '0;
					pad_phase = PH_IDLE;
				end
			end
			FUNC_DATA_RD: begin
				if ((pad_status & ST_RX_READY) != 0) begin
					if (pad_pos == LAST_POS) begin
						pad_status = (pad_status & ~ST_RX_READY) | ST_TX_EMPTY;
						if (pad_phase == PH_REPLY)
							pad_phase = PH_IDLE;
						replies_drained++;
					end
					case (pad_pos)
						3'd0: r.read_data = REPLY_HEAD;
						3'd1: r.read_data = pad_id;
						3'd2: r.read_data = REPLY_MARK;
						3'd3: r.read_data = pad_lo;
						3'd4: r.read_data = pad_hi;
						default: r.read_data = '0;
					endcase
				end
			end
			FUNC_BUTTON: begin
				pad_buttons[it.button_index] = ~it.button_pressed;
			end
			default: begin
			end
		endcase
		r.status_bits = pad_status;
		return r;
	endfunction

	task automatic add_access(input logic [2:0] f, input logic [15:0] wd,
			input logic [3:0] idx, input logic pressed);
		item_t it;
		it.func = f;
		it.write_data = wd;
		it.button_index = idx;
		it.button_pressed = pressed;
		queued_accesses.push_back(it);
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_port_results.push_back(pad_port_access(offered));
				func_seen[offered.func]++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (queued_accesses.size() != 0) begin
					offered = queued_accesses.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, offered.button_pressed, offered.button_index,
						offered.write_data};
					s_tuser <= offered.func;
					if (sender_calm > 0) begin
						sender_calm--;
					end else begin
						send_gap = draw_gap();
						if ($urandom_range(0, 49) == 0)
							sender_calm = $urandom_range(30, 90);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_port_results.size() == 0) begin
					$error("result %h arrived with no request outstanding", m_tdata);
					errors++;
				end else begin
					exp_r = expected_port_results.pop_front();
					results_checked++;
					if (m_tdata[7:0] !== exp_r.read_data) begin
						$error("read_data: expected %h, got %h", exp_r.read_data, m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[10:8] !== exp_r.status_bits) begin
						$error("status_bits: expected %b, got %b",
							exp_r.status_bits, m_tdata[10:8]);
						errors++;
					end
					if (m_tdata[11] !== exp_r.irq_pulse) begin
						$error("irq_pulse: expected %b, got %b", exp_r.irq_pulse, m_tdata[11]);
						errors++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else if (long_holds < 2 && results_checked >= 300 + 450 * long_holds) begin
				// Hold off long enough for the block to fill and stall its input.
				long_holds++;
				recv_gap = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (receiver_calm > 0) begin
				receiver_calm--;
				m_tready <= 1'b1;
			end else begin
				recv_gap = draw_gap();
				if ($urandom_range(0, 49) == 0)
					receiver_calm = $urandom_range(30, 90);
				if (recv_gap > 0) begin
					recv_gap--;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int          target;
		int          step;
		int          r;
		logic [15:0] ctl;
		logic [7:0]  cmd;

		// Directed accesses: idle behavior, both ports, every command shape.
		add_access(FUNC_STAT_RD, 16'h0000, 4'h0, 1'b0);
		add_access(FUNC_DATA_RD, 16'hFFFF, 4'hF, 1'b1);
		add_access(FUNC_DATA_WR, 16'hFFFF, 4'hF, 1'b1);
		add_access(FUNC_SPARE_FIRST, 16'hFFFF, 4'hF, 1'b1);
		add_access(FUNC_SPARE_LAST, 16'h0001, 4'h0, 1'b0);
		add_access(FUNC_CTRL_WR, CTL_RESET_ERR, 4'h0, 1'b0);
		add_access(FUNC_BUTTON, 16'h0000, 4'h0, 1'b1);
		add_access(FUNC_BUTTON, 16'hFFFF, 4'hF, 1'b1);
		add_access(FUNC_BUTTON, 16'h0000, 4'hF, 1'b0);
		add_access(FUNC_CTRL_WR, CTL_DTR, 4'h0, 1'b0);
		add_access(FUNC_DATA_WR, {8'h00, CMD_START}, 4'h0, 1'b0);
		add_access(FUNC_DATA_WR, {8'hFF, CMD_READ_42}, 4'h0, 1'b0);
		add_access(FUNC_DATA_RD, 16'h0000, 4'h0, 1'b0);
		add_access(FUNC_DATA_WR, 16'h0000, 4'h0, 1'b0);
		add_access(FUNC_DATA_WR, 16'h0000, 4'h0, 1'b0);
		add_access(FUNC_DATA_WR, 16'h0000, 4'h0, 1'b0);
		add_access(FUNC_DATA_RD, 16'h0000, 4'h0, 1'b0);
		add_access(FUNC_CTRL_WR, CTL_PORT2 | CTL_DTR, 4'h0, 1'b0);
		add_access(FUNC_DATA_WR, {8'h00, CMD_START}, 4'h0, 1'b0);
		add_access(FUNC_DATA_WR, {8'h00, CMD_READ_43}, 4'h0, 1'b0);
		add_access(FUNC_DATA_RD, 16'h0000, 4'h0, 1'b0);
		add_access(FUNC_CTRL_WR, 16'hFFFF, 4'h0, 1'b0);
		add_access(FUNC_CTRL_WR, CTL_PORT2, 4'h0, 1'b0);
		add_access(FUNC_DATA_WR, {8'h00, CMD_START}, 4'h0, 1'b0);
		add_access(FUNC_DATA_WR, {8'h00, CMD_SELECT | 8'h3F}, 4'h0, 1'b0);
		add_access(FUNC_CTRL_WR, CTL_RESET | CTL_DTR, 4'h0, 1'b0);
		add_access(FUNC_DATA_WR, {8'h00, CMD_START}, 4'h0, 1'b0);
		add_access(FUNC_DATA_WR, 16'h0000, 4'h0, 1'b0);
		add_access(FUNC_SPARE_FIRST + 3'd1, 16'h0000, 4'h0, 1'b0);

		// Random pad sessions with random content, mixed with noise.
		target = queued_accesses.size() + RANDOM_ACCESSES;
		while (queued_accesses.size() < target) begin
			if ($urandom_range(0, 99) < 85) begin
				if ($urandom_range(0, 9) < 7) begin
					ctl = 16'($urandom);
					ctl = ctl & ~CTL_RESET;
					if ($urandom_range(0, 9) != 0)
						ctl = ctl | CTL_DTR;
					else
						ctl = ctl & ~CTL_DTR;
					if ($urandom_range(0, 9) == 0)
						ctl = ctl | CTL_RESET;
					add_access(FUNC_CTRL_WR, ctl, 4'($urandom), 1'($urandom));
				end
				repeat ($urandom_range(0, 3))
					add_access(FUNC_BUTTON, 16'($urandom), 4'($urandom), 1'($urandom));
				add_access(FUNC_DATA_WR, {8'($urandom), CMD_START}, 4'($urandom), 1'($urandom));
				r = $urandom_range(0, 99);
				if (r < 40)
					cmd = CMD_READ_42;
				else if (r < 70)
					cmd = CMD_READ_43;
				else if (r < 85)
					cmd = CMD_SELECT | 8'($urandom_range(0, 63));
				else
					cmd = 8'($urandom) & ~CMD_SELECT;
				add_access(FUNC_DATA_WR, {8'($urandom), cmd}, 4'($urandom), 1'($urandom));
				if ($urandom_range(0, 11) == 0)
					add_access(FUNC_CTRL_WR, ($urandom_range(0, 1) != 0) ? 16'h0000 :
						(16'($urandom) | CTL_RESET), 4'($urandom), 1'($urandom));
				for (step = 0; step < 4; step++) begin
					repeat ($urandom_range(0, 2))
						add_access(FUNC_DATA_RD, 16'($urandom), 4'($urandom), 1'($urandom));
					if ($urandom_range(0, 4) == 0)
						add_access(FUNC_STAT_RD, 16'($urandom), 4'($urandom), 1'($urandom));
					if (step < 3)
						add_access(FUNC_DATA_WR, 16'($urandom), 4'($urandom), 1'($urandom));
				end
			end else begin
				repeat ($urandom_range(1, 4))
					add_access(3'($urandom_range(0, 7)), 16'($urandom), 4'($urandom),
						1'($urandom));
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (queued_accesses.size() != 0 || s_tvalid || expected_port_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_port_results.size() != 0) begin
			$error("%0d results never arrived", expected_port_results.size());
			errors++;
		end

		$display("Checked %0d results: %0d data writes, %0d control writes, %0d data reads,",
			results_checked, func_seen[FUNC_DATA_WR], func_seen[FUNC_CTRL_WR],
			func_seen[FUNC_DATA_RD]);
		$display("%0d status reads, %0d button events, %0d transfers, %0d replies read out.",
			func_seen[FUNC_STAT_RD], func_seen[FUNC_BUTTON], transfers_started,
			replies_drained);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* files.f */
src/gpsp_pkg.sv
src/gpsp_in_stage.sv
src/gpsp_engine.sv
src/game_pad_serial_port_core.sv
tb/game_pad_serial_port_core_tb.sv
